// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int CURSOR_W    = 11;
  localparam int CELL_IDX_W  = 11;
  localparam int CHAR_W      = 8;
  localparam int CELL_W      = 16;
  localparam int COLOR_W     = 4;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
  localparam logic [7:0]        RESET_ATTR     = 8'h0F;

  localparam logic [COLOR_W-1:0] RESET_FG = 4'hF;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'h0;

  localparam logic [CFG_INDEX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BG = 2'd1;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef struct packed {
    action_t                 action;
    logic [CHAR_W-1:0]       char_code;
    logic [CELL_IDX_W-1:0]   cell_index;
  } item_t;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor_position;
    logic [CELL_W-1:0]   cell_value;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic clear_start;
    logic scroll_start;
    logic scroll_step;
    logic fill_step;
    logic put_char;
    logic newline_move;
    logic bs_write;
    logic read_issue;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    is_newline;
    logic    is_backspace;
    logic    bs_ok;
    logic    past_end;
    logic    nl_scroll;
    logic    scroll_last;
    logic    fill_last;
  } status_t;

endpackage

// ===== sv/tcw_datapath.sv =====
`timescale 1ns / 1ps

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tcw_pkg::cmd_t                 cmd,
  output tcw_pkg::status_t              status,
  input  tcw_pkg::item_t                item_data,
  output tcw_pkg::result_t              result_data,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int MW        = $clog2(CELLS);
  localparam int AW        = $clog2(CELLS + 1);
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS + 1);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  logic [CELL_W-1:0]  cells [CELLS];
  logic [CELL_W-1:0]  rdata;
  logic               rvalid;
  item_t              item_q;
  logic [AW-1:0]      cursor;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [COLOR_W-1:0] fg;
  logic [COLOR_W-1:0] bg;
  logic [MW-1:0]      rptr;
  logic [MW-1:0]      wptr;
  logic [CELL_W-1:0]  fill_val;

  logic [7:0]         attr;
  logic [CELL_W-1:0]  blank;
  logic               we;
  logic [MW-1:0]      waddr;
  logic [CELL_W-1:0]  wdata;
  logic               re;
  logic [MW-1:0]      raddr;
  logic               in_range;

  assign attr     = {bg, fg};
  assign blank    = {attr, CODE_SPACE};
  assign in_range = 32'(item_q.cell_index) < 32'(CELLS);

  // single write port: scroll copy, fill sweep, character or blank store
  always_comb begin
    we    = 1'b1;
    waddr = wptr;
    wdata = fill_val;
    if (rvalid) begin
      wdata = rdata;
    end else if (cmd.fill_step) begin
      wdata = fill_val;
    end else if (cmd.put_char) begin
      waddr = MW'(cursor);
      wdata = {attr, item_q.char_code};
    end else if (cmd.bs_write) begin
      waddr = MW'(cursor - AW'(1));
      wdata = blank;
    end else begin
      we = 1'b0;
    end
  end

  assign re    = cmd.scroll_step | cmd.read_issue;
  assign raddr = cmd.scroll_step ? rptr : MW'(item_q.cell_index);

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
    if (re) begin
      rdata <= cells[raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item_data;
    end
    if (cmd.scroll_start) begin
      rptr <= MW'(COLUMNS);
    end else if (cmd.scroll_step) begin
      rptr <= rptr + MW'(1);
    end
    if (cmd.out_load) begin
      result_data.cursor_position <= CURSOR_W'(cursor);
      result_data.cell_value      <= (item_q.action == ACT_READ && in_range) ? rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor   <= '0;
      col      <= '0;
      row      <= '0;
      fg       <= RESET_FG;
      bg       <= RESET_BG;
      wptr     <= '0;
      fill_val <= {RESET_ATTR, CODE_SPACE};
      rvalid   <= 1'b0;
    end else begin
      rvalid <= cmd.scroll_step;
      if (cfg_we) begin
        case (cfg_index)
          REG_FG:  fg <= cfg_data;
          REG_BG:  bg <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.scroll_start) begin
        wptr     <= '0;
        fill_val <= blank;
        cursor   <= AW'(LAST_BASE);
        row      <= RW'(ROWS - 1);
        col      <= '0;
      end else if (cmd.clear_start) begin
        wptr     <= '0;
        fill_val <= blank;
        cursor   <= '0;
        row      <= '0;
        col      <= '0;
      end else if (rvalid || cmd.fill_step) begin
        wptr <= wptr + MW'(1);
      end
      if (cmd.put_char) begin
        cursor <= cursor + AW'(1);
        if (col == CW'(COLUMNS - 1)) begin
          col <= '0;
          row <= row + RW'(1);
        end else begin
          col <= col + CW'(1);
        end
      end else if (cmd.newline_move) begin
        cursor <= cursor - AW'(col) + AW'(COLUMNS);
        row    <= row + RW'(1);
        col    <= '0;
      end else if (cmd.bs_write) begin
        cursor <= cursor - AW'(1);
        col    <= col - CW'(1);
      end
    end
  end

  always_comb begin
    status.act          = item_q.action;
    status.is_newline   = item_q.char_code == CODE_NEWLINE;
    status.is_backspace = item_q.char_code == CODE_BACKSPACE;
    status.bs_ok        = col != '0;
    status.past_end     = row == RW'(ROWS);
    status.nl_scroll    = row >= RW'(ROWS - 1);
    status.scroll_last  = rptr == MW'(CELLS - 1);
    status.fill_last    = wptr == MW'(CELLS - 1);
  end

endmodule

// ===== sv/tcw_ctrl.sv =====
`timescale 1ns / 1ps

module tcw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  tcw_pkg::status_t status,
  output tcw_pkg::cmd_t    cmd
);
  import tcw_pkg::*;

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_DECODE = 8'b0000_0100,
    ST_SCROLL = 8'b0000_1000,
    ST_DRAIN  = 8'b0001_0000,
    ST_FILL   = 8'b0010_0000,
    ST_PUT    = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_INIT: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_next = ST_DONE;
        case (status.act)
          ACT_PUT: begin
            if (status.is_newline) begin
              if (status.nl_scroll) begin
                cmd.scroll_start = 1'b1;
                state_next       = ST_SCROLL;
              end else begin
                cmd.newline_move = 1'b1;
              end
            end else if (status.is_backspace) begin
              cmd.bs_write = status.bs_ok;
            end else if (status.past_end) begin
              cmd.scroll_start = 1'b1;
              state_next       = ST_SCROLL;
            end else begin
              cmd.put_char = 1'b1;
            end
          end
          ACT_CLEAR: begin
            cmd.clear_start = 1'b1;
            state_next      = ST_FILL;
          end
          ACT_READ: begin
            cmd.read_issue = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
        if (status.scroll_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last copied row lands this cycle
        state_next = ST_FILL;
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (status.fill_last) begin
          if (status.act == ACT_PUT && !status.is_newline && !status.is_backspace) begin
            state_next = ST_PUT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_PUT: begin
        cmd.put_char = 1'b1;
        state_next   = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign item_stall = state != ST_IDLE;

endmodule

// ===== sv/text_console_writer.sv =====
`timescale 1ns / 1ps

// Text console engine over a COLUMNS x ROWS store of 16-bit cells (attribute
// high byte, character low byte) with a cursor. One transaction is taken at a
// time. Plain puts, backspace, newline without scroll and reads pass through a
// decode state and a done state, and the next transaction is accepted only once
// the result is loaded. Scroll and clear sweep the cell memory through its
// single write port, one cell per cycle: a scroll copies rows up and blanks the
// last row, a clear blanks every cell. After reset a clearing pass over all
// COLUMNS*ROWS cells runs before the first transaction is accepted; config
// writes are taken at any time, but should only be issued while idle. The
// finished result sits in an output register, so a stalled result does not
// block accepting the next transaction.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  tcw_pkg::item_t                  item_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output tcw_pkg::result_t                result_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item_data   (item_data),
    .result_data (result_data),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // one transaction in flight: stall goes up right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("second transaction accepted while one is in work");

  // the clearing pass holds off input when reset drops
  a_init_blocks: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> item_stall)
    else $error("input accepted before the clearing pass");

  // cursor never goes beyond the past-end position
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (32'(result_data.cursor_position) <= 32'(CELLS)))
    else $error("cursor out of range");

  // a result is only produced after the controller loads it
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.out_load))
    else $error("result valid without a load");

endmodule

// ===== tb/sv/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int COLS      = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLS * ROWS;
  localparam int PRINT_CAP = 40;

  localparam logic [1:0]             ACT_UNUSED   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  item_t                  item_data    = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  result_t                result_data;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [COLOR_W-1:0]     cfg_data     = '0;

  // shadow console
  logic [CELL_W-1:0]  screen_image [CELLS];
  int unsigned        cursor_model;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  result_t pending_results [$];

  int error_count;
  int item_count;
  int work_items;
  int gapless_left;
  int scroll_count;
  int past_end_count;
  int clear_count;
  int read_count;

  text_console_writer #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item_data   (item_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_data (result_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [CELL_W-1:0] blank_word();
    return {bg_color, fg_color, CODE_SPACE};
  endfunction

  function automatic void scroll_image();
    logic [CELL_W-1:0] b;
    b = blank_word();
    for (int i = 0; i < CELLS - COLS; i++)
      screen_image[CELL_IDX_W'(i)] = screen_image[CELL_IDX_W'(i + COLS)];
    for (int i = CELLS - COLS; i < CELLS; i++) screen_image[CELL_IDX_W'(i)] = b;
    scroll_count++;
  endfunction

  function automatic result_t console_predict(item_t it);
    result_t r;
    logic [CELL_W-1:0] b;
    r = '0;
    case (it.action)
      ACT_PUT: begin
        if (it.char_code == CODE_NEWLINE) begin
          cursor_model = (cursor_model / COLS + 1) * COLS;
          if (cursor_model >= CELLS) begin
            scroll_image();
            cursor_model = CELLS - COLS;
          end
        end else if (it.char_code == CODE_BACKSPACE) begin
          // no-op at a row start, which includes the past-end position
          if (cursor_model % COLS != 0 && cursor_model <= CELLS) begin
            cursor_model--;
            screen_image[CELL_IDX_W'(cursor_model)] = blank_word();
          end
        end else begin
          if (cursor_model >= CELLS) begin
            scroll_image();
            cursor_model = CELLS - COLS;
          end
          screen_image[CELL_IDX_W'(cursor_model)] = {bg_color, fg_color, it.char_code};
          cursor_model++;
          if (cursor_model == CELLS) past_end_count++;
        end
      end
      ACT_CLEAR: begin
        b = blank_word();
        for (int i = 0; i < CELLS; i++) screen_image[CELL_IDX_W'(i)] = b;
        cursor_model = 0;
        clear_count++;
      end
      ACT_READ: begin
        read_count++;
        if (it.cell_index < CELLS) r.cell_value = screen_image[it.cell_index];
      end
      default: ;
    endcase
    r.cursor_position = cursor_model[CURSOR_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected transaction: cursor %0d cell %h",
                             result_data.cursor_position, result_data.cell_value));
      end else begin
        want = pending_results.pop_front();
        if (result_data.cursor_position !== want.cursor_position)
          flag_error($sformatf("cursor_position got %0d want %0d",
                               result_data.cursor_position, want.cursor_position));
        if (result_data.cell_value !== want.cell_value)
          flag_error($sformatf("cell_value got %h want %h",
                               result_data.cell_value, want.cell_value));
      end
    end
  end

  // receiver back-pressure: quiet, light, choppy, or long holds
  initial begin : stall_gen
    int seg_len;
    int mode;
    int hold;
    hold = 0;
    forever begin
      seg_len = $urandom_range(20, 200);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        case (mode)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 9) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          default: begin
            if (hold == 0 && $urandom_range(0, 15) == 0) hold = $urandom_range(10, 40);
            result_stall <= (hold != 0);
            if (hold != 0) hold--;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- driving

  function automatic int next_gap();
    int roll;
    if (gapless_left > 0) begin
      gapless_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      gapless_left = $urandom_range(10, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic send_item(item_t it);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= it;
    do @(posedge clk); while (item_stall);
    pending_results.push_back(console_predict(it));
    item_count++;
    if (it.action != action_t'(ACT_UNUSED)) work_items++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_color(logic [CFG_INDEX_W-1:0] idx, logic [COLOR_W-1:0] val);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_FG) fg_color = val;
    else if (idx == REG_BG) bg_color = val;
  endtask

  function automatic item_t make_item(logic [1:0] act, logic [CHAR_W-1:0] code,
                                      logic [CELL_IDX_W-1:0] idx);
    item_t it;
    it.action     = action_t'(act);
    it.char_code  = code;
    it.cell_index = idx;
    return it;
  endfunction

  function automatic logic [CHAR_W-1:0] random_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CELL_IDX_W-1:0] random_index();
    return CELL_IDX_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    logic [CHAR_W-1:0] c;
    do c = random_byte(); while (c == CODE_NEWLINE || c == CODE_BACKSPACE);
    return c;
  endfunction

  function automatic logic [CELL_IDX_W-1:0] pick_index();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return CELL_IDX_W'($urandom_range(0, CELLS - 1));
    if (roll < 85)
      return CELL_IDX_W'((cursor_model + CELLS - 1 - $urandom_range(0, 2)) % CELLS);
    return CELL_IDX_W'($urandom_range(CELLS, 2047));
  endfunction

  task automatic put_code(logic [CHAR_W-1:0] code);
    send_item(make_item(ACT_PUT, code, random_index()));
  endtask

  task automatic read_cell(logic [CELL_IDX_W-1:0] idx);
    send_item(make_item(ACT_READ, random_byte(), idx));
  endtask

  task automatic send_wipe();
    send_item(make_item(ACT_CLEAR, random_byte(), random_index()));
  endtask

  // ---------------------------------------------------------------- sequences

  task automatic run_text_line();
    int roll;
    repeat ($urandom_range(0, 8)) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) put_code(plain_char());
      else if (roll < 90) put_code(CODE_BACKSPACE);
      else read_cell(pick_index());
    end
    put_code(CODE_NEWLINE);
  endtask

  task automatic run_newlines(int count);
    repeat (count) put_code(CODE_NEWLINE);
  endtask

  // 70 to 90 characters, often enough to wrap a row; at the bottom it can walk through the past-end spot
  task automatic run_long_text();
    repeat ($urandom_range(70, 90)) put_code(plain_char());
    case ($urandom_range(0, 3))
      0: put_code(CODE_NEWLINE);
      1: put_code(CODE_BACKSPACE);
      2: put_code(plain_char());
      default: read_cell(pick_index());
    endcase
  endtask

  task automatic run_reads();
    repeat ($urandom_range(1, 6)) read_cell(pick_index());
  endtask

  task automatic run_noise();
    case ($urandom_range(0, 2))
      0: send_item(make_item(ACT_UNUSED, random_byte(), random_index()));
      1: put_code(random_byte());
      default: read_cell(random_index());
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    read_cell(CELL_IDX_W'(0));
    read_cell(CELL_IDX_W'(CELLS - 1));
    read_cell(CELL_IDX_W'(CELLS));
    read_cell(11'h7FF);
  endtask

  task automatic test_put_and_edit();
    put_code(8'h00);
    put_code(8'hFF);
    put_code(8'h41);
    read_cell(CELL_IDX_W'(0));
    read_cell(CELL_IDX_W'(1));
    put_code(CODE_BACKSPACE);
    read_cell(CELL_IDX_W'(2));
    put_code(CODE_NEWLINE);
    put_code(CODE_BACKSPACE);
    send_item(make_item(ACT_UNUSED, 8'hFF, 11'h7FF));
    send_wipe();
    put_code(CODE_BACKSPACE);
  endtask

  task automatic test_color_registers();
    write_color(REG_FG, 4'h0);
    write_color(REG_BG, 4'hF);
    // writes to unused indexes must leave the colors alone
    write_color(REG_SPARE_LO, 4'h5);
    write_color(REG_SPARE_HI, 4'hA);
    put_code(8'h5A);
    read_cell(CELL_IDX_W'(0));
    put_code(CODE_BACKSPACE);
    read_cell(CELL_IDX_W'(0));
    send_wipe();
    read_cell(CELL_IDX_W'(CELLS - 1));
  endtask

  task automatic test_bottom_of_screen();
    run_newlines(ROWS + $urandom_range(0, 3));
    run_long_text();
    run_text_line();
  endtask

  task automatic test_random_traffic(int quota);
    int stop_at;
    int roll;
    stop_at = work_items + quota;
    while (work_items < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) run_text_line();
      else if (roll < 62) run_newlines($urandom_range(1, 30));
      else if (roll < 72) run_long_text();
      else if (roll < 85) run_reads();
      else if (roll < 88) send_wipe();
      else run_noise();
    end
  endtask

  task automatic test_color_sweep();
    write_color(REG_FG, COLOR_W'($urandom_range(0, 15)));
    write_color(REG_BG, COLOR_W'($urandom_range(0, 15)));
    test_random_traffic(60);
    write_color(REG_FG, 4'h0);
    write_color(REG_BG, 4'h0);
    test_random_traffic(60);
    write_color(REG_FG, 4'hF);
    write_color(REG_BG, 4'hF);
    test_random_traffic(60);
    write_color(REG_FG, COLOR_W'($urandom_range(0, 15)));
    write_color(REG_BG, COLOR_W'($urandom_range(0, 15)));
    test_random_traffic(50);
  endtask

  initial begin
    fg_color     = RESET_FG;
    bg_color     = RESET_BG;
    cursor_model = 0;
    for (int i = 0; i < CELLS; i++) screen_image[CELL_IDX_W'(i)] = {RESET_ATTR, CODE_SPACE};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_put_and_edit();
    test_color_registers();
    test_bottom_of_screen();
    test_color_sweep();
    wait_idle();
    repeat (20) @(posedge clk);

    $display("sent %0d transactions: %0d reads, %0d clears, %0d scrolls,",
             item_count, read_count, clear_count, scroll_count);
    $display("cursor reached past-end %0d times; %0d mismatches", past_end_count, error_count);
    if (error_count == 0) begin
      $display("text_console_writer regression: pass");
    end else begin
      $display("text_console_writer regression: fail");
    end
    $finish;
  end

  // covers every transaction taking a full scroll plus worst-case stalls, several times over
  initial begin
    #40_000_000;
    $display("timeout with %0d transactions outstanding", pending_results.size());
    $display("text_console_writer regression: fail");
    $finish;
  end

endmodule
